// ===== src/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants for the peak preserving trace decimator.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int unsigned DEF_CHANNELS = 16;
  localparam int unsigned DEF_COLUMNS  = 2048;

  localparam int unsigned STEP_W = 17;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned COL_OUT_W = 11;

  localparam logic [STEP_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic signed [15:0] INVALID_SAMPLE = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         channel;
    logic               first_of_screen;
    logic               frame_end;
  } smp_t;

  typedef struct packed {
    logic [3:0]           out_channel;
    logic [COL_OUT_W-1:0] column;
    logic signed [15:0]   point_value;
    logic                 point_valid;
  } pt_t;

  // per-channel state word held in the state memory
  typedef struct packed {
    logic signed [15:0] ref_val;
    logic signed [15:0] run_max;
    logic signed [15:0] run_min;
    logic               seen;
  } chst_t;

endpackage

// ===== src/ppd_smp_if.sv =====
// ----------------------------------------------------------------------------
// ppd_smp_if / ppd_pt_if
// Valid/ready channels for samples in and column points out.
// ----------------------------------------------------------------------------
interface ppd_smp_if;
  logic          valid;
  logic          ready;
  ppd_pkg::smp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppd_pt_if;
  logic         valid;
  logic         ready;
  ppd_pkg::pt_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ppd_state_ram.sv =====
// ----------------------------------------------------------------------------
// ppd_state_ram
// Per-channel state memory: one read and one write port, registered read.
// Entries never written read as zero; a write to the address read in the
// same cycle is passed through to the read data.
// ----------------------------------------------------------------------------
module ppd_state_ram #(
  parameter int unsigned CHANNELS = ppd_pkg::DEF_CHANNELS,
  parameter int unsigned AW       = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output ppd_pkg::chst_t       rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  ppd_pkg::chst_t       wr_data_i
);

  ppd_pkg::chst_t mem_q [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  ppd_pkg::chst_t rd_data_q;
  logic rd_vld_q;
  logic rd_hit;

  assign rd_hit = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= rd_hit ? wr_data_i : mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= rd_hit || vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== src/ppd_core.sv =====
// ----------------------------------------------------------------------------
// ppd_core
// Update stage: merges one sample into its channel state, decides the
// column crossing, writes the state back and loads the output register.
// ----------------------------------------------------------------------------
module ppd_core #(
  parameter int unsigned CHANNELS = ppd_pkg::DEF_CHANNELS,
  parameter int unsigned COLUMNS  = ppd_pkg::DEF_COLUMNS,
  parameter int unsigned AW       = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppd_pkg::STEP_W-1:0]    cfg_wdata_i,
  ppd_smp_if.sink                       smp_i,
  ppd_pt_if.source                      pt_o,
  output logic                          rd_en_o,
  output logic [AW-1:0]                 rd_addr_o,
  input  ppd_pkg::chst_t                rd_data_i,
  output logic                          wr_en_o,
  output logic [AW-1:0]                 wr_addr_o,
  output ppd_pkg::chst_t                wr_data_o
);

  localparam int unsigned CW = $clog2(COLUMNS);

  logic [ppd_pkg::STEP_W-1:0]  step_q;
  logic [ppd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [CW-1:0]               col_q, col_d;

  logic          s1_vld_q;
  ppd_pkg::smp_t s1_q;
  logic          s1_fire, accept;

  logic          out_vld_q;
  ppd_pkg::pt_t  out_q, out_d;
  logic          emit;

  logic               in_range, ok, carry, can_adv, ok_gt, ok_lt, seen_n, pick_max;
  logic [ppd_pkg::STEP_W-1:0] sum;
  logic signed [15:0] s, mx, mn, pick;
  logic signed [16:0] up_d, dn_d;
  ppd_pkg::chst_t     st, st_n;

  assign s1_fire   = s1_vld_q && (!out_vld_q || pt_o.ready);
  assign accept    = smp_i.valid && smp_i.ready;
  assign smp_i.ready = !s1_vld_q || s1_fire;
  assign rd_en_o   = accept;
  assign rd_addr_o = AW'(smp_i.data.channel);

  assign st       = rd_data_i;
  assign s        = s1_q.sample;
  assign in_range = 32'(s1_q.channel) < CHANNELS;
  assign ok       = s != ppd_pkg::INVALID_SAMPLE;
  assign sum      = ppd_pkg::STEP_W'(phase_q) + step_q;
  assign carry    = sum[ppd_pkg::STEP_W-1];
  assign can_adv  = carry && (col_q != CW'(COLUMNS - 1));

  assign ok_gt  = ok && (s > st.run_max);
  assign ok_lt  = ok && (s < st.run_min);
  assign mx     = ok_gt ? s : st.run_max;
  assign mn     = ok_lt ? s : st.run_min;
  assign seen_n = st.seen || ok;
  assign up_d   = $signed({mx[15], mx}) - $signed({st.ref_val[15], st.ref_val});
  assign dn_d   = $signed({st.ref_val[15], st.ref_val}) - $signed({mn[15], mn});
  assign pick_max = up_d > dn_d;
  assign pick   = pick_max ? mx : mn;

  always_comb begin
    st_n    = st;
    out_d   = '0;
    emit    = 1'b0;
    phase_d = phase_q;
    col_d   = col_q;
    out_d.out_channel = s1_q.channel;
    if (s1_q.first_of_screen) begin
      st_n.ref_val = s;
      st_n.run_max = s;
      st_n.run_min = s;
      st_n.seen    = 1'b0;
      out_d.column      = '0;
      out_d.point_value = s;
      out_d.point_valid = ok;
      emit    = in_range;
      phase_d = '0;
      col_d   = '0;
    end else begin
      st_n.run_max = mx;
      st_n.run_min = mn;
      st_n.seen    = seen_n;
      out_d.column = ppd_pkg::COL_OUT_W'(col_q + CW'(1));
      if (can_adv) begin
        emit = in_range;
        st_n.seen = 1'b0;
        if (seen_n) begin
          st_n.ref_val = pick;
          st_n.run_max = pick;
          st_n.run_min = pick;
          out_d.point_value = pick;
          out_d.point_valid = 1'b1;
        end else begin
          out_d.point_value = st.ref_val;
          out_d.point_valid = 1'b0;
        end
      end
      if (s1_q.frame_end) begin
        phase_d = sum[ppd_pkg::PHASE_W-1:0];
        if (can_adv) begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  assign wr_en_o   = s1_fire && in_range;
  assign wr_addr_o = AW'(s1_q.channel);
  assign wr_data_o = st_n;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= smp_i.data;
    end
    if (s1_fire && emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= ppd_pkg::ONE_Q16;
      phase_q   <= '0;
      col_q     <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= (cfg_wdata_i > ppd_pkg::ONE_Q16) ? ppd_pkg::ONE_Q16 : cfg_wdata_i;
      end
      if (s1_fire) begin
        phase_q <= phase_d;
        col_q   <= col_d;
      end
      if (smp_i.ready) begin
        s1_vld_q <= smp_i.valid;
      end
      if (s1_fire) begin
        out_vld_q <= emit;
      end else if (pt_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign pt_o.valid = out_vld_q;
  assign pt_o.data  = out_q;

endmodule

// ===== src/peak_preserving_trace_decimator.sv =====
// ----------------------------------------------------------------------------
// peak_preserving_trace_decimator
// Min/max decimation of a multichannel sample stream to display columns.
// ----------------------------------------------------------------------------
// Takes one channel sample per clock; backpressure on the point output
// stalls the update stage and then the sample input. Points leave from an
// output register behind the update stage. Per-channel reference, max, min
// and seen flag live in a one-read/one-write state memory with a registered
// read; the update stage writes back each sample of an in-range channel and
// a write to the channel being read in the same cycle is bypassed to the
// read data, so repeated samples of one channel need no stall. Phase, column
// and step are held in registers of the update stage.
// ----------------------------------------------------------------------------
module peak_preserving_trace_decimator #(
  parameter int unsigned CHANNELS = ppd_pkg::DEF_CHANNELS,
  parameter int unsigned COLUMNS  = ppd_pkg::DEF_COLUMNS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ppd_pkg::STEP_W-1:0] cfg_wdata_i,
  ppd_smp_if.sink                    smp_i,
  ppd_pt_if.source                   pt_o
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  ppd_pkg::chst_t rd_data, wr_data;

  ppd_state_ram #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  ppd_core #(
    .CHANNELS (CHANNELS),
    .COLUMNS  (COLUMNS),
    .AW       (AW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .smp_i       (smp_i),
    .pt_o        (pt_o),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the peak preserving trace decimator.
// A predictor tracks per-channel reference, max, min and seen
// flags plus the shared column phase. Every accepted sample updates it and
// queues any column point it must cause. Every point taken from the block is
// checked field by field against the oldest queued point. Stimulus: directed
// corner cases, a backpressure burst, then random screens under changing
// column steps and random idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_GAP     = 12;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_TAIL   = 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_GOAL = 1300;

  class column_predictor;
    logic signed [15:0]            ref_val [ppd_pkg::DEF_CHANNELS];
    logic signed [15:0]            run_max [ppd_pkg::DEF_CHANNELS];
    logic signed [15:0]            run_min [ppd_pkg::DEF_CHANNELS];
    bit                            seen    [ppd_pkg::DEF_CHANNELS];
    logic [ppd_pkg::PHASE_W-1:0]   phase;
    logic [ppd_pkg::COL_OUT_W-1:0] cur_col;
    logic [ppd_pkg::STEP_W-1:0]    step;
    ppd_pkg::pt_t                  pending_points [$];
    int unsigned                   points_seen, gap_points, errors;

    function new();
      for (int i = 0; i < ppd_pkg::DEF_CHANNELS; i++) begin
        ref_val[i] = '0;
        run_max[i] = '0;
        run_min[i] = '0;
        seen[i]    = 1'b0;
      end
      phase   = '0;
      cur_col = '0;
      step    = ppd_pkg::ONE_Q16;
    endfunction

    function void set_step(logic [ppd_pkg::STEP_W-1:0] v);
      step = (v > ppd_pkg::ONE_Q16) ? ppd_pkg::ONE_Q16 : v;
    endfunction

    function int unsigned pending();
      return pending_points.size();
    endfunction

    function void take_sample(ppd_pkg::smp_t s);
      logic [ppd_pkg::STEP_W:0] sum;
      bit                       ok, adv;
      int                       hi_d, lo_d;
      int unsigned              ch;
      ppd_pkg::pt_t             p;
      ch = 32'(s.channel);
      ok = (s.sample != ppd_pkg::INVALID_SAMPLE);
      if (s.first_of_screen) begin
        phase   = '0;
        cur_col = '0;
        if (ch < ppd_pkg::DEF_CHANNELS) begin
          ref_val[ch] = s.sample;
          run_max[ch] = s.sample;
          run_min[ch] = s.sample;
          seen[ch]    = 1'b0;
          p.out_channel = s.channel;
          p.column      = '0;
          p.point_value = s.sample;
          p.point_valid = ok;
          pending_points.push_back(p);
        end
        return;
      end
      sum = (ppd_pkg::STEP_W+1)'(phase) + (ppd_pkg::STEP_W+1)'(step);
      adv = (sum >= (ppd_pkg::STEP_W+1)'(ppd_pkg::ONE_Q16)) &&
            (cur_col != ppd_pkg::COL_OUT_W'(ppd_pkg::DEF_COLUMNS - 1));
      if (ch < ppd_pkg::DEF_CHANNELS) begin
        if (ok) begin
          if (s.sample > run_max[ch]) run_max[ch] = s.sample;
          if (s.sample < run_min[ch]) run_min[ch] = s.sample;
          seen[ch] = 1'b1;
        end
        if (adv) begin
          p.out_channel = s.channel;
          p.column      = cur_col + ppd_pkg::COL_OUT_W'(1);
          if (seen[ch]) begin
            hi_d = int'(run_max[ch]) - int'(ref_val[ch]);
            lo_d = int'(ref_val[ch]) - int'(run_min[ch]);
            if (hi_d > lo_d) begin
              ref_val[ch] = run_max[ch];
              run_min[ch] = run_max[ch];
            end else begin
              ref_val[ch] = run_min[ch];
              run_max[ch] = run_min[ch];
            end
            p.point_valid = 1'b1;
          end else begin
            p.point_valid = 1'b0;
          end
          p.point_value = ref_val[ch];
          seen[ch] = 1'b0;
          pending_points.push_back(p);
        end
      end
      if (s.frame_end) begin
        if (adv) cur_col = cur_col + ppd_pkg::COL_OUT_W'(1);
        phase = sum[ppd_pkg::PHASE_W-1:0];
      end
    endfunction

    function void check_point(ppd_pkg::pt_t got);
      ppd_pkg::pt_t want;
      if (pending_points.size() == 0) begin
        $error("unexpected point: channel %0d column %0d value %0d valid %0b",
               got.out_channel, got.column, got.point_value, got.point_valid);
        errors++;
        return;
      end
      want = pending_points.pop_front();
      points_seen++;
      if (!got.point_valid) gap_points++;
      if (got.out_channel !== want.out_channel) begin
        $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
        errors++;
      end
      if (got.column !== want.column) begin
        $error("column: expected %0d, got %0d", want.column, got.column);
        errors++;
      end
      if (got.point_value !== want.point_value) begin
        $error("point_value: expected %0d, got %0d", want.point_value, got.point_value);
        errors++;
      end
      if (got.point_valid !== want.point_valid) begin
        $error("point_valid: expected %0b, got %0b", want.point_valid, got.point_valid);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [ppd_pkg::STEP_W-1:0] cfg_wdata_i;

  ppd_smp_if smp_bus ();
  ppd_pt_if  pt_bus ();

  column_predictor sb = new();

  bit          src_gaps  = 1'b1;
  bit          sink_gaps = 1'b1;
  bit          noise_on  = 1'b1;
  bit          hold_req  = 1'b0;
  int unsigned samples_sent;
  int unsigned steps_written;
  int unsigned quiet_cycles;

  peak_preserving_trace_decimator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .smp_i       (smp_bus.sink),
    .pt_o        (pt_bus.source)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && smp_bus.valid && smp_bus.ready) sb.take_sample(smp_bus.data);
    if (rst_ni && pt_bus.valid && pt_bus.ready) sb.check_point(pt_bus.data);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (smp_bus.valid && smp_bus.ready) || (pt_bus.valid && pt_bus.ready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // point receiver
  initial begin
    int unsigned w;
    pt_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pt_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      w = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (w != 0) begin
        pt_bus.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      pt_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!pt_bus.valid) @(posedge clk_i);
    end
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return ppd_pkg::INVALID_SAMPLE;
      1:       return 16'sh7FFF;
      2:       return 16'sh8001;
      3:       return 16'($urandom_range(0, 16)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ppd_pkg::STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return ppd_pkg::ONE_Q16;
      1:       return 17'h08000;
      2:       return 17'($urandom_range(1, 65536));
      3:       return 17'($urandom_range(16384, 65536));
      4:       return 17'($urandom_range(0, 17'h1FFFF));
      default: return 17'($urandom_range(1, 512));
    endcase
  endfunction

  task automatic send_sample(input ppd_pkg::smp_t s);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      smp_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_bus.valid <= 1'b1;
    smp_bus.data  <= s;
    @(posedge clk_i);
    while (!smp_bus.ready) @(posedge clk_i);
    samples_sent++;
  endtask

  task automatic put(input logic signed [15:0] v, input logic [3:0] ch, input bit first,
                     input bit fend);
    ppd_pkg::smp_t s;
    s.sample          = v;
    s.channel         = ch;
    s.first_of_screen = first;
    s.frame_end       = fend;
    send_sample(s);
  endtask

  // stop offering, let every queued point drain, then give in-flight work time
  task automatic settle_block();
    smp_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (IDLE_TAIL) @(posedge clk_i);
  endtask

  task automatic write_column_step(input logic [ppd_pkg::STEP_W-1:0] v);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_step(v);
    steps_written++;
  endtask

  // one screen: per sample time a random channel subset, frame_end on the last
  task automatic send_screen(input int unsigned n_times, input int unsigned n_ch,
                             input bit mixed_first);
    int unsigned   order [ppd_pkg::DEF_CHANNELS];
    int unsigned   j, tmp;
    ppd_pkg::smp_t s;
    for (int i = 0; i < ppd_pkg::DEF_CHANNELS; i++) order[i] = i;
    for (int unsigned t = 0; t < n_times; t++) begin
      for (int i = ppd_pkg::DEF_CHANNELS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int unsigned k = 0; k < n_ch; k++) begin
        if (noise_on && $urandom_range(0, 19) == 0) begin
          s = ppd_pkg::smp_t'($urandom);
        end else begin
          s.sample          = pick_sample();
          s.channel         = 4'(order[k]);
          s.first_of_screen = (t == 0) && (!mixed_first || $urandom_range(0, 1) == 1);
          s.frame_end       = (k == n_ch - 1);
        end
        send_sample(s);
      end
    end
  endtask

  initial begin
    int unsigned goal;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    smp_bus.valid <= 1'b0;
    smp_bus.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state, pass-through, invalid first sample, gaps
    put(16'sd3, 4'd5, 1'b0, 1'b1);
    put(16'sh7FFF, 4'd0, 1'b1, 1'b0);
    put(ppd_pkg::INVALID_SAMPLE, 4'd15, 1'b1, 1'b1);
    put(-16'sd32767, 4'd0, 1'b0, 1'b0);
    put(16'sd100, 4'd15, 1'b0, 1'b1);
    put(ppd_pkg::INVALID_SAMPLE, 4'd0, 1'b0, 1'b0);
    put(ppd_pkg::INVALID_SAMPLE, 4'd15, 1'b0, 1'b1);
    // half step: tie between max and min, mixed first flags
    write_column_step(17'h08000);
    put(16'sd0, 4'd3, 1'b1, 1'b1);
    put(16'sd100, 4'd3, 1'b0, 1'b1);
    put(-16'sd100, 4'd3, 1'b0, 1'b1);
    put(16'sd50, 4'd3, 1'b0, 1'b1);
    put(16'sd50, 4'd3, 1'b0, 1'b1);
    put(16'sd5, 4'd1, 1'b1, 1'b0);
    put(16'sd7, 4'd2, 1'b0, 1'b1);
    put(-16'sd9, 4'd1, 1'b0, 1'b0);
    put(16'sd9, 4'd2, 1'b0, 1'b1);
    // zero step never advances
    write_column_step('0);
    put(16'sd1, 4'd6, 1'b1, 1'b1);
    put(16'sd2, 4'd6, 1'b0, 1'b1);
    put(-16'sd2, 4'd6, 1'b0, 1'b1);
    // oversized step saturates to one column per sample time
    write_column_step(17'h1FFFF);
    put(16'sd11, 4'd7, 1'b1, 1'b1);
    put(-16'sd11, 4'd7, 1'b0, 1'b1);
    put(ppd_pkg::INVALID_SAMPLE, 4'd7, 1'b0, 1'b1);
    write_column_step(17'h00001);
    put(16'sd4, 4'd8, 1'b1, 1'b1);
    put(-16'sd4, 4'd8, 1'b0, 1'b1);

    // backpressure burst: receiver holds off while samples keep coming
    write_column_step(ppd_pkg::ONE_Q16);
    src_gaps = 1'b0;
    hold_req = 1'b1;
    send_screen(30, 4, 1'b0);
    settle_block();
    src_gaps = 1'b1;

    goal = samples_sent + RANDOM_GOAL;
    while (samples_sent < goal) begin
      if ($urandom_range(0, 2) == 0) write_column_step(pick_step());
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      send_screen($urandom_range(2, 24),
                  $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 16),
                  $urandom_range(0, 7) == 0);
    end

    settle_block();
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected points never arrived", sb.pending());
      sb.errors++;
    end
    $display("tb: %0d samples sent, %0d points checked, %0d of them gaps",
             samples_sent, sb.points_seen, sb.gap_points);
    $display("tb: %0d column step writes, with stalls from both sides",
             steps_written);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ppd_pkg.sv
src/ppd_smp_if.sv
src/ppd_state_ram.sv
src/ppd_core.sv
src/peak_preserving_trace_decimator.sv
tb/tb.sv
